// ===== sv/lpeq_pkg.sv =====
// ============================================================================
// lpeq_pkg - shared types and constants for the lossy priority event queue
// Widths, status and register codes, and the lossy-kind test used by the
// sequencer.
// ============================================================================
`default_nettype none

package lpeq_pkg;

    // Queue geometry
    localparam int DEPTH        = 16;
    localparam int KIND_BITS    = 4;
    localparam int PAYLOAD_BITS = 64;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int MASK_W = 16;
    localparam int DEACT_W = 4;

    localparam logic REG_LOSSY_MASK = 1'b0;
    localparam logic REG_DEACT_KIND = 1'b1;

    // Result status codes
    localparam logic [2:0] STAT_PUSHED    = 3'd0;
    localparam logic [2:0] STAT_REJECTED  = 3'd1;
    localparam logic [2:0] STAT_COLLAPSED = 3'd2;
    localparam logic [2:0] STAT_POPPED    = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    typedef logic [KIND_BITS-1:0]    t_kind;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [MASK_W-1:0]       t_mask;
    typedef logic [DEACT_W-1:0]      t_deact;

    typedef struct packed {
        logic     en;
        t_idx     addr;
        t_kind    kind;
        t_payload payload;
    } t_wr_port;

    typedef struct packed {
        logic [2:0] status;
        t_kind      kind;
        t_payload   payload;
    } t_result;

    // Kinds beyond the mask width are never lossy.
    function automatic logic kind_is_lossy(t_mask mask, t_kind kind);
        logic [7:0] k8;
        k8 = 8'(kind);
        return (k8 < 8'd16) && mask[k8[3:0]];
    endfunction

endpackage

`default_nettype wire

// ===== sv/lpeq_store.sv =====
// ============================================================================
// lpeq_store - event entry memory
// Kind and payload arrays with one write port and one registered read port.
// ============================================================================
`default_nettype none

module lpeq_store (
    input  wire logic                i_clk,
    input  wire lpeq_pkg::t_wr_port  i_wr,
    input  wire lpeq_pkg::t_idx      i_rd_addr,
    output lpeq_pkg::t_kind          o_rd_kind,
    output lpeq_pkg::t_payload       o_rd_payload
);

    lpeq_pkg::t_kind    r_kind_mem [lpeq_pkg::DEPTH];
    lpeq_pkg::t_payload r_pay_mem  [lpeq_pkg::DEPTH];
    lpeq_pkg::t_kind    r_rd_kind;
    lpeq_pkg::t_payload r_rd_payload;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_kind_mem[i_wr.addr] <= i_wr.kind;
            r_pay_mem[i_wr.addr]  <= i_wr.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_kind    <= r_kind_mem[i_rd_addr];
        r_rd_payload <= r_pay_mem[i_rd_addr];
    end

    assign o_rd_kind    = r_rd_kind;
    assign o_rd_payload = r_rd_payload;

endmodule

`default_nettype wire

// ===== sv/lpeq_slot_unit.sv =====
// ============================================================================
// lpeq_slot_unit - shared slot address unit
// Map a logical position behind the head to a physical slot, wrapping at
// the queue depth.
// ============================================================================
`default_nettype none

module lpeq_slot_unit (
    input  wire lpeq_pkg::t_idx i_head,
    input  wire lpeq_pkg::t_cnt i_logical,
    output lpeq_pkg::t_idx      o_slot
);

    logic [lpeq_pkg::SUM_W-1:0] sum;
    logic [lpeq_pkg::SUM_W-1:0] wrapped;

    always_comb begin
        sum = lpeq_pkg::SUM_W'(i_head) + lpeq_pkg::SUM_W'(i_logical);
        if (sum >= lpeq_pkg::SUM_W'(lpeq_pkg::DEPTH)) begin
            wrapped = sum - lpeq_pkg::SUM_W'(lpeq_pkg::DEPTH);
        end else begin
            wrapped = sum;
        end
    end

    assign o_slot = wrapped[lpeq_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

// ===== sv/lpeq_ctrl.sv =====
// ============================================================================
// lpeq_ctrl - queue sequencer
// Run one transaction at a time: pop, append, or the scan and shift that
// make room in a full queue, or reject or collapse, via the shared slot unit.
// ============================================================================
`default_nettype none

module lpeq_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_mode,
    input  wire lpeq_pkg::t_kind     i_kind,
    input  wire lpeq_pkg::t_payload  i_payload,
    input  wire lpeq_pkg::t_mask     i_lossy_mask,
    input  wire lpeq_pkg::t_deact    i_deact_kind,
    input  wire logic                i_done_ack,
    output logic                     o_busy,
    output logic                     o_done,
    output lpeq_pkg::t_result        o_result,
    output lpeq_pkg::t_wr_port       o_wr,
    output lpeq_pkg::t_idx           o_rd_addr,
    input  wire lpeq_pkg::t_kind     i_rd_kind,
    input  wire lpeq_pkg::t_payload  i_rd_payload
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SH_RD,
        S_SH_WR,
        S_APPEND,
        S_DONE
    } t_state;

    localparam lpeq_pkg::t_idx LAST_IDX = lpeq_pkg::IDX_W'(lpeq_pkg::DEPTH - 1);
    localparam lpeq_pkg::t_cnt FULL_CNT = lpeq_pkg::CNT_W'(lpeq_pkg::DEPTH);

    t_state             r_state, n_state;
    logic               r_mode, n_mode;
    lpeq_pkg::t_kind    r_kind, n_kind;
    lpeq_pkg::t_payload r_payload, n_payload;
    lpeq_pkg::t_idx     r_head, n_head;
    lpeq_pkg::t_cnt     r_count, n_count;
    lpeq_pkg::t_idx     r_idx, n_idx;
    lpeq_pkg::t_idx     r_dst, n_dst;
    lpeq_pkg::t_idx     r_src, n_src;
    lpeq_pkg::t_result  r_result, n_result;

    lpeq_pkg::t_cnt     logical;
    lpeq_pkg::t_idx     slot;

    lpeq_slot_unit u_slot (
        .i_head    (r_head),
        .i_logical (logical),
        .o_slot    (slot)
    );

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_kind    = r_kind;
        n_payload = r_payload;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_dst     = r_dst;
        n_src     = r_src;
        n_result  = r_result;

        o_wr.en      = 1'b0;
        o_wr.addr    = r_dst;
        o_wr.kind    = r_kind;
        o_wr.payload = r_payload;
        o_rd_addr    = r_head;

        case (r_state)
            S_DISPATCH: logical = r_count;
            S_POP_WAIT: logical = lpeq_pkg::CNT_W'(1);
            default:    logical = lpeq_pkg::CNT_W'(r_idx);
        endcase

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode    = i_mode;
                    n_kind    = i_kind;
                    n_payload = i_payload;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_result = '0;
                if (r_mode) begin
                    if (r_count == '0) begin
                        n_result.status = lpeq_pkg::STAT_EMPTY;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_POP_WAIT;
                    end
                end else if (r_count != FULL_CNT) begin
                    o_wr.en         = 1'b1;
                    o_wr.addr       = slot;
                    n_count         = r_count + 1'b1;
                    n_result.status = lpeq_pkg::STAT_PUSHED;
                    n_state         = S_DONE;
                end else begin
                    n_idx   = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_POP_WAIT: begin
                n_result.status  = lpeq_pkg::STAT_POPPED;
                n_result.kind    = i_rd_kind;
                n_result.payload = i_rd_payload;
                n_head           = slot;
                n_count          = r_count - 1'b1;
                n_state          = S_DONE;
            end
            S_SCAN_RD: begin
                o_rd_addr = slot;
                n_dst     = slot;
                n_state   = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (lpeq_pkg::kind_is_lossy(i_lossy_mask, i_rd_kind)) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = S_APPEND;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SH_RD;
                    end
                end else if (r_idx == LAST_IDX) begin
                    if (lpeq_pkg::kind_is_lossy(i_lossy_mask, r_kind)) begin
                        n_result.status = lpeq_pkg::STAT_REJECTED;
                    end else begin
                        // Collapse to a lone deactivate event in slot zero.
                        o_wr.en         = 1'b1;
                        o_wr.addr       = '0;
                        o_wr.kind       = lpeq_pkg::KIND_BITS'(i_deact_kind);
                        o_wr.payload    = '0;
                        n_head          = '0;
                        n_count         = lpeq_pkg::CNT_W'(1);
                        n_result.status = lpeq_pkg::STAT_COLLAPSED;
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                o_rd_addr = slot;
                n_src     = slot;
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                o_wr.en      = 1'b1;
                o_wr.kind    = i_rd_kind;
                o_wr.payload = i_rd_payload;
                n_dst        = r_src;
                if (r_idx == LAST_IDX) begin
                    n_state = S_APPEND;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SH_RD;
                end
            end
            S_APPEND: begin
                o_wr.en         = 1'b1;
                n_result.status = lpeq_pkg::STAT_PUSHED;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_kind    <= n_kind;
        r_payload <= n_payload;
        r_idx     <= n_idx;
        r_dst     <= n_dst;
        r_src     <= n_src;
        r_result  <= n_result;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== sv/lossy_priority_event_queue.sv =====
// ============================================================================
// lossy_priority_event_queue - bounded event FIFO with lossy eviction
// A full queue makes room by evicting its oldest lossy entry; with none to
// evict it rejects a lossy event or collapses to a single deactivate event.
// ============================================================================
//
//  Channel   Direction  Handshake                 Carries
//  -------   ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_stall   i_mode, i_event_kind, i_event_payload
//  out       source     o_out_valid / i_out_stall o_status, o_out_kind, o_out_payload
//  cfg       APB slave  psel / penable / pready   lossy_kind_mask @0, deactivate_kind @4
//
//  Sequencing: one transaction at a time. A non-full push is written from
//  the dispatch state; a pop passes through dispatch and a read-wait state.
//  A push into a full queue scans and then shifts entries through the entry
//  store, each entry taking a read state and then a check or write state
//  because of its registered read, before it appends, rejects or collapses.
//  Reset: synchronous, active low; clears head, count, config registers,
//  output valid and sequencer state. Entry contents stay; only filled slots are read.
//  Stalls: o_in_stall is high while a transaction is in flight; a result held
//  by i_out_stall waits in the output register while the sequencer parks.
//
`default_nettype none

module lossy_priority_event_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input events
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_mode,
    input  wire logic [3:0]                    i_event_kind,
    input  wire logic [63:0]                   i_event_payload,
    // results
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [2:0]                         o_status,
    output logic [3:0]                         o_out_kind,
    output logic [63:0]                        o_out_payload,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpeq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lpeq_pkg::DATA_W-1:0]   pwdata,
    output logic [lpeq_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    lpeq_pkg::t_mask  r_lossy_mask;
    lpeq_pkg::t_deact r_deact_kind;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lossy_mask <= '0;
            r_deact_kind <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                lpeq_pkg::REG_LOSSY_MASK: r_lossy_mask <= pwdata[lpeq_pkg::MASK_W-1:0];
                lpeq_pkg::REG_DEACT_KIND: r_deact_kind <= pwdata[lpeq_pkg::DEACT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lpeq_pkg::REG_LOSSY_MASK: prdata = lpeq_pkg::DATA_W'(r_lossy_mask);
            lpeq_pkg::REG_DEACT_KIND: prdata = lpeq_pkg::DATA_W'(r_deact_kind);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and entry store
    // ------------------------------------------------------------------
    logic                busy;
    logic                done;
    logic                done_ack;
    logic                in_take;
    lpeq_pkg::t_result   result;
    lpeq_pkg::t_wr_port  wr;
    lpeq_pkg::t_idx      rd_addr;
    lpeq_pkg::t_kind     rd_kind;
    lpeq_pkg::t_payload  rd_payload;

    // Take a new transaction only while the sequencer is idle.
    assign o_in_stall = busy;
    assign in_take    = i_in_valid && !busy;

    lpeq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_take),
        .i_mode       (i_mode),
        .i_kind       (lpeq_pkg::KIND_BITS'(i_event_kind)),
        .i_payload    (lpeq_pkg::PAYLOAD_BITS'(i_event_payload)),
        .i_lossy_mask (r_lossy_mask),
        .i_deact_kind (r_deact_kind),
        .i_done_ack   (done_ack),
        .o_busy       (busy),
        .o_done       (done),
        .o_result     (result),
        .o_wr         (wr),
        .o_rd_addr    (rd_addr),
        .i_rd_kind    (rd_kind),
        .i_rd_payload (rd_payload)
    );

    lpeq_store u_store (
        .i_clk        (i_clk),
        .i_wr         (wr),
        .i_rd_addr    (rd_addr),
        .o_rd_kind    (rd_kind),
        .o_rd_payload (rd_payload)
    );

    // ------------------------------------------------------------------
    // Output register: load when empty or being drained this cycle
    // ------------------------------------------------------------------
    logic              r_out_valid;
    lpeq_pkg::t_result r_out;

    assign done_ack = done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (done_ack) begin
            r_out <= result;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_out_kind    = 4'(r_out.kind);
    assign o_out_payload = 64'(r_out.payload);

`ifndef SYNTH
    // An accepted transaction holds off the next one.
    a_stall_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // Only defined status codes reach the output.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= lpeq_pkg::STAT_EMPTY))
        else $error("undefined status code on output");

    // Anything other than a pop carries zero kind and payload.
    a_zero_unless_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != lpeq_pkg::STAT_POPPED))
            |-> (o_out_kind == '0 && o_out_payload == '0))
        else $error("non-pop result carries event data");
`endif

endmodule

`default_nettype wire

// ===== bench/lossy_priority_event_queue_tb.sv =====
// ============================================================================
// lossy_priority_event_queue_tb - self-checking bench for the event queue
// Drives push and pop transactions with random gaps against a random-stall
// receiver, mirrors the queue in a behavioural shadow and checks every
// result field by field. Runs through several lossy-mask and deactivate-kind
// settings, including the all-lossy and none-lossy extremes.
// ============================================================================
`default_nettype none

module lossy_priority_event_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpeq_pkg::*;

    // Transaction codes on i_mode
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Generous bound: far above items * (sender gap + full-queue scan + stall)
    localparam int unsigned LIMIT_CYCLES = 400_000;
    localparam int          REPORT_MAX   = 10;
    localparam int          PHASE_ITEMS  = 205;
    localparam int          HOLD_CYCLES  = 600;

    typedef struct packed {
        logic     mode;
        t_kind    kind;
        t_payload payload;
    } queue_request_t;

    typedef struct packed {
        t_kind    kind;
        t_payload payload;
    } stored_entry_t;

    // ------------------------------------------------------------------------
    // Block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                i_mode          = MODE_PUSH;
    t_kind               i_event_kind    = '0;
    t_payload            i_event_payload = '0;
    logic                i_out_stall     = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [ADDR_W-1:0]   paddr           = '0;
    logic [DATA_W-1:0]   pwdata          = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [2:0]          o_status;
    t_kind               o_out_kind;
    t_payload            o_out_payload;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    lossy_priority_event_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_event_kind    (i_event_kind),
        .i_event_payload (i_event_payload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_out_kind      (o_out_kind),
        .o_out_payload   (o_out_payload),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------------
    // Clock: 8 ns period
    // ------------------------------------------------------------------------
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    queue_request_t         pending_requests[$];  // transactions not yet accepted
    lpeq_pkg::t_result      result_backlog[$];    // results owed by the block
    stored_entry_t          shadow_fifo[$];       // logical queue contents, head first
    t_mask                  lossy_mask_r = '0;
    t_deact                 deact_kind_r = '0;

    logic                   in_taken  = 1'b0;     // input transaction at last rising edge
    logic                   out_taken = 1'b0;     // result transaction at last rising edge
    logic                   hold_off  = 1'b0;     // long receiver back-pressure window
    int unsigned            requests_sent = 0;
    int unsigned            mismatch_count = 0;
    int unsigned            cycle_count = 0;

    // ------------------------------------------------------------------------
    // Shadow queue: advance it by one accepted transaction and owe a result.
    // A full queue evicts its oldest lossy entry; failing that, a lossy
    // arrival is turned away and anything else wipes the queue down to one
    // deactivate event.
    // ------------------------------------------------------------------------
    task automatic step_event_queue(input logic mode, input t_kind kind,
                                    input t_payload payload);
        lpeq_pkg::t_result res;
        stored_entry_t     head;
        logic              room;
        int                i;

        res = '0;
        if (mode == MODE_POP) begin
            if (shadow_fifo.size() == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                head        = shadow_fifo.pop_front();
                res.status  = STAT_POPPED;
                res.kind    = head.kind;
                res.payload = head.payload;
            end
        end else begin
            room = 1'b1;
            if (shadow_fifo.size() >= DEPTH) begin
                room = 1'b0;
                for (i = 0; i < shadow_fifo.size() && !room; i++) begin
                    if (lossy_mask_r[shadow_fifo[i].kind]) begin
                        shadow_fifo.delete(i);
                        room = 1'b1;
                    end
                end
            end
            if (room) begin
                shadow_fifo.push_back('{kind: kind, payload: payload});
                res.status = STAT_PUSHED;
            end else if (lossy_mask_r[kind]) begin
                res.status = STAT_REJECTED;
            end else begin
                shadow_fifo.delete();
                shadow_fifo.push_back('{kind: t_kind'(deact_kind_r), payload: '0});
                res.status = STAT_COLLAPSED;
            end
        end
        result_backlog.push_back(res);
    endtask

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Rising edge: take both handshakes. Outputs are read before the block's
    // own nonblocking updates land, so every sample is the pre-edge value.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        lpeq_pkg::t_result want;

        if (i_rst_n) begin
            in_taken  <= i_in_valid && !o_in_stall;
            out_taken <= o_out_valid && !i_out_stall;

            if (i_in_valid && !o_in_stall)
                step_event_queue(i_mode, i_event_kind, i_event_payload);

            if (o_out_valid && !i_out_stall) begin
                if (result_backlog.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result status %0d kind %0h payload %h",
                                            o_status, o_out_kind, o_out_payload));
                end else begin
                    want = result_backlog.pop_front();
                    if (o_status !== want.status || o_out_kind !== want.kind ||
                        o_out_payload !== want.payload)
                        flag_mismatch($sformatf(
                            "expected status %0d kind %0h payload %h, got %0d %0h %h",
                            want.status, want.kind, want.payload,
                            o_status, o_out_kind, o_out_payload));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: present the head of pending_requests at the falling edge, hold
    // it until accepted, then wait a drawn number of cycles. Quiet stretches
    // drop the gaps to zero for a while.
    // ------------------------------------------------------------------------
    logic        offering = 1'b0;
    logic        tx_quiet = 1'b0;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && (!offering || in_taken)) begin
            if (offering) begin
                pending_requests.delete(0);
                requests_sent++;
                offering = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    tx_quiet = !tx_quiet;
                gap_left = tx_quiet ? 0 : $urandom_range(0, 11);
            end
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_requests.size() != 0) begin
                offering         = 1'b1;
                i_mode          <= pending_requests[0].mode;
                i_event_kind    <= pending_requests[0].kind;
                i_event_payload <= pending_requests[0].payload;
            end
            i_in_valid <= offering;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: after each result draw a stall length; the hold-off window
    // overrides it with continuous back-pressure.
    // ------------------------------------------------------------------------
    logic        rx_quiet   = 1'b0;
    int unsigned stall_left = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 29) == 0)
                    rx_quiet = !rx_quiet;
                stall_left = rx_quiet ? 0 : $urandom_range(0, 11);
            end
            i_out_stall <= hold_off || (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Hold the receiver off once traffic is flowing, so the block backs up
    // and stalls its input while the sender keeps offering.
    initial begin
        while (requests_sent < 300)
            @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Abort on a hung run
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("lossy_priority_event_queue_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Configuration access: write one register, read it back and check it.
    // Upper data bits carry noise that the block must mask off.
    // ------------------------------------------------------------------------
    task automatic program_register(input logic reg_sel, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] keep;
        logic [DATA_W-1:0] seen;

        keep = (reg_sel == REG_LOSSY_MASK) ? DATA_W'({MASK_W{1'b1}})
                                           : DATA_W'({DEACT_W{1'b1}});

        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);

        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seen = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;

        if (reg_sel == REG_LOSSY_MASK)
            lossy_mask_r = t_mask'(value);
        else
            deact_kind_r = t_deact'(value);

        if (seen !== (value & keep))
            flag_mismatch($sformatf("register %0d read back %h, expected %h",
                                    reg_sel, seen, value & keep));
    endtask

    task automatic set_queue_config(input t_mask mask, input t_deact deact);
        program_register(REG_LOSSY_MASK, {16'($urandom), mask});
        program_register(REG_DEACT_KIND, {28'($urandom), deact});
    endtask

    task automatic add_request(input logic mode, input t_kind kind, input t_payload payload);
        pending_requests.push_back('{mode: mode, kind: kind, payload: payload});
    endtask

    // Random traffic in runs of 24 with a push bias per run: fill-heavy runs
    // keep the queue full so eviction, rejection and collapse come up often,
    // drain-heavy runs empty it again.
    task automatic add_random_requests(input int count);
        int       i;
        int       push_bias;
        t_payload pay;

        push_bias = 70;
        for (i = 0; i < count; i++) begin
            if (i % 24 == 0) begin
                case ($urandom_range(0, 3))
                    0:       push_bias = 25;
                    1:       push_bias = 60;
                    default: push_bias = 88;
                endcase
            end
            case ($urandom_range(0, 7))
                0:       pay = '0;
                1:       pay = '1;
                default: pay = {$urandom, $urandom};
            endcase
            add_request(($urandom_range(1, 100) > push_bias) ? MODE_POP : MODE_PUSH,
                        t_kind'($urandom_range(0, 15)), pay);
        end
    endtask

    // Idle point: every accepted transaction answered and nothing queued
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || result_backlog.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int k;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: kinds 0..7 lossy, deactivate kind 0xA
        set_queue_config(16'h00FF, 4'hA);
        add_request(MODE_POP,  '0,    '0);          // pop on empty queue
        add_request(MODE_PUSH, 4'h0,  '0);
        add_request(MODE_PUSH, 4'hF,  '1);
        add_request(MODE_POP,  '0,    '0);
        add_request(MODE_POP,  '0,    '0);
        add_request(MODE_POP,  '1,    '1);          // empty again, junk fields
        // fill with non-lossy kinds only
        for (k = 0; k < DEPTH; k++)
            add_request(MODE_PUSH, t_kind'(8 + (k % 8)), {$urandom, $urandom});
        add_request(MODE_PUSH, 4'h3,  64'h0123_4567_89AB_CDEF);  // lossy, no victim
        add_request(MODE_PUSH, 4'h9,  64'hFEDC_BA98_7654_3210);  // collapse
        add_request(MODE_POP,  '0,    '0);          // deactivate event comes out
        wait_for_drain();

        // Extremes first, then mixed settings
        set_queue_config(16'hFFFF, 4'h0);
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        set_queue_config(16'h0000, 4'hF);
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        set_queue_config(16'h5555, 4'h7);
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        set_queue_config(16'h8001, t_deact'($urandom));
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        set_queue_config(t_mask'($urandom), t_deact'($urandom));
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        set_queue_config(t_mask'($urandom), t_deact'($urandom));
        add_random_requests(PHASE_ITEMS);
        wait_for_drain();

        // Let any stray result surface before the verdict
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (result_backlog.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", result_backlog.size()));

        if (mismatch_count == 0) begin
            $display("lossy_priority_event_queue_tb OK");
        end else begin
            $display("lossy_priority_event_queue_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/lpeq_pkg.sv
sv/lpeq_store.sv
sv/lpeq_slot_unit.sv
sv/lpeq_ctrl.sv
sv/lossy_priority_event_queue.sv
bench/lossy_priority_event_queue_tb.sv
